### sv/ehp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ehp_pkg
// Shared types, codes and helper functions of the element header parser.
// ----------------------------------------------------------------------------
package ehp_pkg;

  localparam logic [3:0] MaxIdBytes   = 4'd4;
  localparam logic [3:0] MaxVintBytes = 4'd8;

  localparam logic [1:0] MODE_HEADER   = 2'd0;
  localparam logic [1:0] MODE_UNSIGNED = 2'd1;
  localparam logic [1:0] MODE_SIGNED   = 2'd2;
  localparam logic [1:0] MODE_RAW      = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_LONG_ID  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_RAW_LEN = 1'b1;

  typedef enum logic [1:0] {
    KIND_ERR,
    KIND_RAW,
    KIND_VINT
  } ehp_kind_e;

  typedef struct packed {
    ehp_kind_e   kind;
    logic [1:0]  status;
    logic [1:0]  mode;
    logic [63:0] value;
    logic [3:0]  len;
    logic [3:0]  hlen;
    logic [31:0] held_id;
    logic [31:0] start_off;
  } ehp_rec_t;

  // 1..8 from the position of the leading one, 9 for a zero byte
  function automatic logic [3:0] lead_len(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd9;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(8 - i);
    end
    return n;
  endfunction

  // ones over the 7*len value bits of a vint
  function automatic logic [63:0] vint_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len) m[7*i +: 7] = 7'h7f;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### sv/ehp_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ehp_regs
// APB-style register file: decode mode and raw integer length.
// ----------------------------------------------------------------------------
module ehp_regs
  import ehp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [1:0]       decode_mode_o,
  output logic [3:0]       raw_length_o
);

  logic       wr_en;
  logic [1:0] mode_q;
  logic [3:0] raw_len_q;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_HEADER;
      raw_len_q <= 4'd1;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MODE:    mode_q    <= pwdata[1:0];
        REG_RAW_LEN: raw_len_q <= pwdata[3:0];
        default:     mode_q    <= mode_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:    prdata = {30'd0, mode_q};
      REG_RAW_LEN: prdata = {28'd0, raw_len_q};
      default:     prdata = '0;
    endcase
  end

  assign decode_mode_o = mode_q;
  assign raw_length_o  = raw_len_q;

endmodule
`default_nettype wire

### sv/ehp_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ehp_decode
// Byte-wise parse state machine; registers one record per finished item.
// ----------------------------------------------------------------------------
module ehp_decode
  import ehp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        start_req_i,
  input  wire logic [31:0] item_offset_i,
  input  wire logic [1:0]  decode_mode_i,
  input  wire logic [3:0]  raw_length_i,
  output logic             rec_valid_o,
  output ehp_rec_t         rec_o,
  input  wire logic        rec_ready_i
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ID,
    PH_VINT,
    PH_RAW
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  seen_q, seen_d;
  logic [3:0]  vlen_q, vlen_d;
  logic [31:0] id_q, id_d;
  logic [3:0]  hcnt_q, hcnt_d;
  logic [31:0] soff_q, soff_d;
  logic        rec_valid_q;
  ehp_rec_t    rec_q, rec_d;
  logic        emit;
  logic        fail;
  logic        take;
  logic [3:0]  llen;
  logic [3:0]  raw_n;

  assign in_ready_o = !rec_valid_q || rec_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign llen       = lead_len(data_byte_i);

  always_comb begin
    if (raw_length_i == 4'd0) begin
      raw_n = 4'd1;
    end else if (raw_length_i > 4'd8) begin
      raw_n = 4'd8;
    end else begin
      raw_n = raw_length_i;
    end
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    seen_d  = seen_q;
    vlen_d  = vlen_q;
    id_d    = id_q;
    hcnt_d  = hcnt_q;
    soff_d  = soff_q;
    emit    = 1'b0;
    fail    = 1'b0;
    rec_d   = rec_q;

    if (start_req_i) begin
      case (decode_mode_i)
        MODE_HEADER: phase_d = PH_ID;
        MODE_RAW:    phase_d = PH_RAW;
        default:     phase_d = PH_VINT;
      endcase
      acc_d  = '0;
      seen_d = '0;
      vlen_d = '0;
      id_d   = '0;
      hcnt_d = '0;
      soff_d = item_offset_i;
    end

    if (phase_d != PH_IDLE) begin
      acc_d  = {acc_d[55:0], data_byte_i};
      seen_d = seen_d + 4'd1;
      rec_d.mode      = decode_mode_i;
      rec_d.value     = acc_d;
      rec_d.held_id   = id_d;
      rec_d.start_off = soff_d;
      rec_d.len       = vlen_d;
      rec_d.status    = ST_OK;
      if (phase_d == PH_RAW) begin
        if (seen_d >= raw_n) begin
          emit       = 1'b1;
          rec_d.kind = KIND_RAW;
          rec_d.hlen = raw_n;
          phase_d    = PH_IDLE;
        end
      end else begin
        if (seen_d == 4'd1) begin
          if (data_byte_i == 8'd0) begin
            fail         = 1'b1;
            rec_d.status = ST_ZERO;
          end else if (phase_d == PH_ID && llen > MaxIdBytes) begin
            fail         = 1'b1;
            rec_d.status = ST_LONG_ID;
          end else if (phase_d == PH_VINT && llen > MaxVintBytes) begin
            fail         = 1'b1;
            rec_d.status = ST_ZERO;
          end else begin
            vlen_d = llen;
          end
        end
        if (fail) begin
          emit       = 1'b1;
          rec_d.kind = KIND_ERR;
          rec_d.hlen = hcnt_d + seen_d;
          phase_d    = PH_IDLE;
        end else if (seen_d >= vlen_d) begin
          if (phase_d == PH_ID) begin
            id_d    = acc_d[31:0];
            hcnt_d  = vlen_d;
            phase_d = PH_VINT;
            acc_d   = '0;
            seen_d  = '0;
            vlen_d  = '0;
          end else begin
            emit       = 1'b1;
            rec_d.kind = KIND_VINT;
            rec_d.len  = vlen_d;
            rec_d.hlen = hcnt_d + vlen_d;
            phase_d    = PH_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      acc_q       <= '0;
      seen_q      <= '0;
      vlen_q      <= '0;
      id_q        <= '0;
      hcnt_q      <= '0;
      soff_q      <= '0;
      rec_valid_q <= 1'b0;
    end else if (take) begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      seen_q      <= seen_d;
      vlen_q      <= vlen_d;
      id_q        <= id_d;
      hcnt_q      <= hcnt_d;
      soff_q      <= soff_d;
      rec_valid_q <= emit;
    end else if (rec_ready_i) begin
      rec_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      rec_q <= rec_d;
    end
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

endmodule
`default_nettype wire

### sv/ehp_result.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ehp_result
// Forms value, offsets and status from a parse record; output register.
// ----------------------------------------------------------------------------
module ehp_result
  import ehp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         rec_valid_i,
  input  wire ehp_rec_t     rec_i,
  output logic              rec_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [31:0]       element_id_o,
  output logic [63:0]       unsigned_value_o,
  output logic signed [55:0] signed_value_o,
  output logic [3:0]        header_length_o,
  output logic [31:0]       body_offset_o,
  output logic [31:0]       body_end_o,
  output logic [31:0]       total_length_o,
  output logic              unknown_size_o,
  output logic [1:0]        status_o
);

  logic        out_valid_q;
  logic        load;
  logic [63:0] vmask;
  logic [63:0] value;
  logic [31:0] doff;
  logic [56:0] total;
  logic        ovf;
  logic [5:0]  sidx;
  logic        sbit;

  logic [31:0] id_d, id_q;
  logic [63:0] uv_d, uv_q;
  logic [55:0] sv_d, sv_q;
  logic [3:0]  hlen_d, hlen_q;
  logic [31:0] doff_q;
  logic [31:0] eoff_d, eoff_q;
  logic [31:0] esz_d, esz_q;
  logic        unk_d, unk_q;
  logic [1:0]  st_d, st_q;

  assign rec_ready_o = !out_valid_q || out_ready_i;
  assign load        = rec_valid_i && rec_ready_o;

  assign vmask = vint_mask(rec_i.len);
  assign value = rec_i.value & vmask;
  assign doff  = rec_i.start_off + {28'd0, rec_i.hlen};
  assign total = {25'd0, rec_i.start_off} + {53'd0, rec_i.hlen} + value[56:0];
  assign ovf   = |total[56:32];
  assign sidx  = 6'(({2'd0, rec_i.len} << 3) - {2'd0, rec_i.len} - 6'd1);
  assign sbit  = value[sidx];

  always_comb begin
    id_d   = '0;
    uv_d   = '0;
    sv_d   = '0;
    hlen_d = rec_i.hlen;
    eoff_d = '0;
    esz_d  = '0;
    unk_d  = 1'b0;
    st_d   = ST_OK;
    case (rec_i.kind)
      KIND_ERR: begin
        id_d = rec_i.held_id;
        st_d = rec_i.status;
      end
      KIND_RAW: begin
        uv_d = rec_i.value;
      end
      KIND_VINT: begin
        case (rec_i.mode)
          MODE_HEADER: begin
            id_d = rec_i.held_id;
            uv_d = value;
            if (value == vmask) begin
              unk_d  = 1'b1;
              eoff_d = '1;
              esz_d  = '1;
            end else if (ovf) begin
              st_d = ST_OVERFLOW;
            end else begin
              eoff_d = total[31:0];
              esz_d  = value[31:0] + {28'd0, rec_i.hlen};
            end
          end
          MODE_SIGNED: begin
            sv_d = value[55:0] | (sbit ? ~vmask[55:0] : 56'd0);
          end
          default: begin
            uv_d = value;
          end
        endcase
      end
      default: begin
        st_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      id_q   <= id_d;
      uv_q   <= uv_d;
      sv_q   <= sv_d;
      hlen_q <= hlen_d;
      doff_q <= doff;
      eoff_q <= eoff_d;
      esz_q  <= esz_d;
      unk_q  <= unk_d;
      st_q   <= st_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign element_id_o     = id_q;
  assign unsigned_value_o = uv_q;
  assign signed_value_o   = sv_q;
  assign header_length_o  = hlen_q;
  assign body_offset_o    = doff_q;
  assign body_end_o       = eoff_q;
  assign total_length_o   = esz_q;
  assign unknown_size_o   = unk_q;
  assign status_o         = st_q;

endmodule
`default_nettype wire

### sv/ebml_element_header_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebml_element_header_parser_unit
// EBML element header / vint / raw integer parser, one byte per request.
// path: a result passes the decode record register and then the result output register
// throughput: one byte per cycle while in_ready_o is high, set by the byte-wise parse state machine
// a waiting result does not stop input until the record stage behind it fills
// reset clears parse state and pipeline valids; decode mode 0, raw length 1
// ----------------------------------------------------------------------------
module ebml_element_header_parser_unit
  import ehp_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          start_req_i,
  input  wire logic [31:0]   item_offset_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [31:0]        element_id_o,
  output logic [63:0]        unsigned_value_o,
  output logic signed [55:0] signed_value_o,
  output logic [3:0]         header_length_o,
  output logic [31:0]        body_offset_o,
  output logic [31:0]        body_end_o,
  output logic [31:0]        total_length_o,
  output logic               unknown_size_o,
  output logic [1:0]         status_o
);

  logic [1:0] decode_mode;
  logic [3:0] raw_length;
  logic       rec_valid;
  logic       rec_ready;
  ehp_rec_t   rec;

  ehp_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .decode_mode_o (decode_mode),
    .raw_length_o  (raw_length)
  );

  ehp_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .start_req_i   (start_req_i),
    .item_offset_i (item_offset_i),
    .decode_mode_i (decode_mode),
    .raw_length_i  (raw_length),
    .rec_valid_o   (rec_valid),
    .rec_o         (rec),
    .rec_ready_i   (rec_ready)
  );

  ehp_result u_result (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_valid_i      (rec_valid),
    .rec_i            (rec),
    .rec_ready_o      (rec_ready),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .element_id_o     (element_id_o),
    .unsigned_value_o (unsigned_value_o),
    .signed_value_o   (signed_value_o),
    .header_length_o  (header_length_o),
    .body_offset_o    (body_offset_o),
    .body_end_o       (body_end_o),
    .total_length_o   (total_length_o),
    .unknown_size_o   (unknown_size_o),
    .status_o         (status_o)
  );

endmodule
`default_nettype wire

### sv/ehp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ehp_checker
// Port-level assertions for the element header parser, bound to the top.
// ----------------------------------------------------------------------------
module ehp_checker
  import ehp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] unsigned_value_o,
  input wire logic [3:0]  header_length_o,
  input wire logic [31:0] body_end_o,
  input wire logic [31:0] total_length_o,
  input wire logic        unknown_size_o,
  input wire logic [1:0]  status_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(unsigned_value_o)
      && $stable(status_o))
    else $error("result changed while stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> body_end_o == 32'd0
      && total_length_o == 32'd0 && !unknown_size_o)
    else $error("error result carries offsets");

  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unknown_size_o |-> status_o == ST_OK
      && body_end_o == 32'hffff_ffff && total_length_o == 32'hffff_ffff)
    else $error("unknown size result malformed");

  a_hlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> header_length_o <= 4'd12)
    else $error("header length out of range");

endmodule

bind ebml_element_header_parser_unit ehp_checker u_ehp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .pready           (pready),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .unsigned_value_o (unsigned_value_o),
  .header_length_o  (header_length_o),
  .body_end_o       (body_end_o),
  .total_length_o   (total_length_o),
  .unknown_size_o   (unknown_size_o),
  .status_o         (status_o)
);
`default_nettype wire
